[rtl/lwe_encrypt_column_accumulator_defines.svh]
// Assertion macros for the LWE column accumulator.
// Used by the top level only; depends on nothing else.
`ifndef LWE_ENCRYPT_COLUMN_ACCUMULATOR_DEFINES_SVH
`define LWE_ENCRYPT_COLUMN_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWECA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lweca: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LWECA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lweca: next-cycle check failed");

`endif

[rtl/lweca_pkg.sv]
// Package of the LWE column accumulator: payload structs, widths and states.
// No dependencies.
package lweca_pkg;

	localparam int COL_W      = 11;
	localparam int MOD_W      = 31;
	localparam int COLS_W     = 12;
	localparam int ACC_W      = 64;
	localparam int PK_W       = 32;
	localparam int SMP_W      = 16;
	localparam int PROD_W     = PK_W + SMP_W;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_COLS_D = 2048;

	localparam logic [CFG_IDX_W-1:0] CFG_PK_MODULUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_MODULUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE   = 2'd2;

	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_FINISH     = 1'b1;

	typedef struct packed {
		logic                    command;
		logic [COL_W-1:0]        column;
		logic signed [PK_W-1:0]  pk_element;
		logic signed [SMP_W-1:0] secret_sample;
		logic signed [SMP_W-1:0] noise_sample;
		logic                    message_bit;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0] out_column;
		logic [MOD_W-1:0] ct_value;
	} out_item_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ADD,
		S_START,
		S_DIV,
		S_EMIT
	} state_t;

endpackage

[rtl/lwe_encrypt_column_accumulator.sv]
// LWE column accumulator: an accumulate item is accepted, multiplied and written back.
// A finish item is accepted, summed and reduced by the 64-step bit-serial remainder unit, and
// frees the input in the same cycle as its result appears; a held output delays both.
// One item is in work at a time.
// After reset a clearing pass zeroes every entry of the accumulator memory, during which
// no item is accepted; configuration writes are taken at all times.
module lwe_encrypt_column_accumulator #(
	parameter int MAX_COLS = lweca_pkg::MAX_COLS_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lweca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lweca_pkg::MOD_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lweca_pkg::in_item_t             in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output lweca_pkg::out_item_t            out_item
);
	import lweca_pkg::*;

	`include "lwe_encrypt_column_accumulator_defines.svh"

	localparam int AW = $clog2(MAX_COLS);

	// Configuration registers, written at any time the port enables them.
	logic [MOD_W-1:0]  pk_mod_q;
	logic [MOD_W-1:0]  total_mod_q;
	logic [COLS_W-1:0] cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_mod_q    <= MOD_W'(1);
			total_mod_q <= MOD_W'(1);
			cols_q      <= COLS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PK_MODULUS:    pk_mod_q    <= cfg_data;
				CFG_TOTAL_MODULUS: total_mod_q <= cfg_data;
				CFG_COLS_IN_USE:   cols_q      <= cfg_data[COLS_W-1:0];
				default:           ;
			endcase
		end
	end

	state_t state_q, state_d;

	logic in_acc;
	logic col_ok;
	logic [12:0] col_ext;

	assign in_acc  = in_valid && !in_stall;
	assign col_ext = 13'(in_item.column);
	assign col_ok  = col_ext < 13'(MAX_COLS);

	// The accepted item is held for the whole of its work.
	in_item_t item_q;
	logic [AW-1:0] item_addr;
	logic [12:0]   item_ext;

	assign item_ext  = 13'(item_q.column);
	assign item_addr = item_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_item;
		end
	end

	// Clearing pass counter.
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Accumulator memory; the read is issued on the accept edge from the incoming column.
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [ACC_W-1:0] mem_wdata;
	logic [ACC_W-1:0] mem_rdata;
	logic [AW-1:0]    mem_raddr;

	assign mem_raddr = col_ext[AW-1:0];

	lweca_acc_mem #(
		.DEPTH(MAX_COLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (in_acc),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Product of the key word and the secret sample, registered before the add.
	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_s1 <= item_q.pk_element * item_q.secret_sample;
		end
	end

	// Sums for the write-back of an accumulate and for the finish of a column.
	logic [ACC_W-1:0] acc_sum;
	logic [ACC_W-1:0] fin_sum;
	logic [ACC_W-1:0] msg_term;
	logic             is_last;

	assign acc_sum  = mem_rdata + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign is_last  = (cols_q != '0) && ({1'b0, item_q.column} == (cols_q - 1'b1));
	assign msg_term = (is_last && item_q.message_bit) ?
		{{(ACC_W-MOD_W+2){1'b0}}, total_mod_q[MOD_W-1:2]} : '0;
	assign fin_sum  = mem_rdata
		+ {{(ACC_W-SMP_W){item_q.noise_sample[SMP_W-1]}}, item_q.noise_sample}
		+ msg_term;

	logic [ACC_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (state_q == S_ADD) begin
			sum_q <= fin_sum;
		end
	end

	// Remainder unit.
	logic             div_start;
	logic             div_done;
	logic [MOD_W-1:0] div_rem;

	lweca_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (sum_q),
		.modulus(pk_mod_q),
		.done   (div_done),
		.rem    (div_rem)
	);

	// Final correction against total_modulus, applied while the result waits to go out.
	logic [MOD_W-1:0] ct_val;

	assign ct_val = (div_rem > total_mod_q) ? (div_rem - total_mod_q) : div_rem;

	logic out_free;
	logic out_load;

	assign out_free = !out_valid || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath controls.
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = item_addr;
		mem_wdata = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(MAX_COLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && col_ok) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				// An accumulate writes the new sum; a finish clears the entry.
				mem_we = 1'b1;
				if (item_q.command == CMD_ACCUMULATE) begin
					mem_wdata = acc_sum;
					state_d   = S_IDLE;
				end else begin
					state_d = S_START;
				end
			end
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register parts the result from the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item.out_column <= item_q.column;
			out_item.ct_value   <= ct_val;
		end
	end

	// The remainder unit only reports completion while a finish is waiting for it.
	`LWECA_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_done, state_q == S_DIV)
	// A new result appears only out of the emit state.
	`LWECA_ASSERT_NXT(a_out_from_emit, clk, arst_n, state_q != S_EMIT, !$rose(out_valid))
	// An accepted accumulate never leads straight to a result.
	`LWECA_ASSERT_NXT(a_acc_no_result, clk, arst_n,
		in_acc && (in_item.command == CMD_ACCUMULATE), state_q == S_MUL || state_q == S_IDLE)

endmodule

[rtl/lweca_acc_mem.sv]
// Single-port-write, single-port-read accumulator memory, registered read.
// Depends on lweca_pkg for the data width.
module lweca_acc_mem #(
	parameter int DEPTH = lweca_pkg::MAX_COLS_D,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [lweca_pkg::ACC_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [lweca_pkg::ACC_W-1:0] rdata
);
	import lweca_pkg::*;

	logic [ACC_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/lweca_mod_unit.sv]
// Bit-serial signed remainder of a 64-bit word by a 31-bit modulus, made non-negative.
// Depends on lweca_pkg for widths.
module lweca_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lweca_pkg::ACC_W-1:0] acc,
	input  logic [lweca_pkg::MOD_W-1:0] modulus,
	output logic                        done,
	output logic [lweca_pkg::MOD_W-1:0] rem
);
	import lweca_pkg::*;

	localparam int CNT_W = $clog2(ACC_W) + 1;

	logic [ACC_W-1:0] mag_q;
	logic [MOD_W-1:0] r_q;
	logic [MOD_W-1:0] m_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MOD_W:0]   r_sh;
	logic [MOD_W:0]   diff;
	logic [MOD_W-1:0] r_next;

	assign r_sh   = {r_q, mag_q[ACC_W-1]};
	assign diff   = r_sh - {1'b0, m_q};
	assign r_next = (r_sh >= {1'b0, m_q}) ? diff[MOD_W-1:0] : r_sh[MOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= acc[ACC_W-1];
			mag_q <= acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
			m_q   <= modulus;
			r_q   <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[ACC_W-2:0], 1'b0};
			r_q   <= r_next;
		end
	end

	assign done = done_q;

	always_comb begin
		if (m_q == '0) begin
			rem = '0;
		end else if (neg_q && (r_q != '0)) begin
			rem = m_q - r_q;
		end else begin
			rem = r_q;
		end
	end

endmodule
